[design/mopq_pkg.sv]
package mopq_pkg;

   // operation codes
   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_ADVANCE = 2'd1;
   localparam logic [1:0] OP_RETIRE  = 2'd2;

   // status codes
   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   localparam int SRC_W   = 4;
   localparam int STAMP_W = 32;
   localparam int OCC_W   = 5;

   typedef struct packed {
      logic [SRC_W-1:0]   src;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // operation broadcast to every cell, already qualified against full/empty
   typedef struct packed {
      logic insert;
      logic advance;
      logic retire;
   } cell_ctl_type;

   // what a cell shows its neighbors
   typedef struct packed {
      entry_type ent;
      logic      valid;
      logic      gt;
   } link_type;

endpackage

[design/mopq_cell.sv]
module mopq_cell (
   input  logic                   clock,
   input  mopq_pkg::cell_ctl_type ctl,
   input  mopq_pkg::entry_type    new_ent,
   input  logic                   first,
   input  logic                   occ,
   input  mopq_pkg::link_type     left,
   input  mopq_pkg::link_type     right,
   output mopq_pkg::link_type     self
);

   mopq_pkg::entry_type ent_ff;
   mopq_pkg::entry_type ent_in;

   logic gt;
   logic ins_here;
   logic adv_vl;
   logic adv_gl;
   logic adv_here;

   // new entry goes before this one (strictly earlier)
   assign gt = occ && (new_ent.stamp < ent_ff.stamp);

   // first free slot takes the entry when nothing held is later; the head cell has no left
   assign ins_here = (gt && !left.gt) || (!occ && (first || left.valid) && !left.gt);

   // advance view: head removed, so this cell's left neighbor is itself
   assign adv_vl   = first || occ;
   assign adv_gl   = !first && gt;
   assign adv_here = (right.gt && !adv_gl) || (!right.valid && adv_vl && !adv_gl);

   always_comb begin
      ent_in = ent_ff;
      if (ctl.insert) begin
         if (left.gt) begin
            ent_in = left.ent;
         end else if (ins_here) begin
            ent_in = new_ent;
         end
      end else if (ctl.advance) begin
         if (adv_gl) begin
            ent_in = ent_ff;
         end else if (adv_here) begin
            ent_in = new_ent;
         end else begin
            ent_in = right.ent;
         end
      end else if (ctl.retire) begin
         ent_in = right.ent;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
   end

   assign self.ent   = ent_ff;
   assign self.valid = occ;
   assign self.gt    = gt;

endmodule

[design/merge_order_priority_queue_top.sv]
// channel   | ports                                               | direction
// ----------+-----------------------------------------------------+----------
// request   | start, busy (out), req_operation, req_source_id,    | in
//           | req_timestamp                                       |
// response  | rsp_valid, rsp_head_valid, rsp_head_source,         | out
//           | rsp_head_time, rsp_occupancy, rsp_status            |
//
// one transaction is taken every cycle; busy stays low
// the response appears in the cycle after the request and lasts one cycle
// insert, advance and retire each take effect inside the cell row; the response shows the updated row
// synchronous active-high reset empties the queue; entry contents stay undefined
// the receiver cannot stall, so no response is ever held back
module merge_order_priority_queue_top #(
   parameter int MAX_SOURCES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_operation,
   input  logic [mopq_pkg::SRC_W-1:0]    req_source_id,
   input  logic [mopq_pkg::STAMP_W-1:0]  req_timestamp,
   output logic                          rsp_valid,
   output logic                          rsp_head_valid,
   output logic [mopq_pkg::SRC_W-1:0]    rsp_head_source,
   output logic [mopq_pkg::STAMP_W-1:0]  rsp_head_time,
   output logic [mopq_pkg::OCC_W-1:0]    rsp_occupancy,
   output logic [1:0]                    rsp_status
);

   localparam int CW = $clog2(MAX_SOURCES + 1);

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic          rsp_valid_ff;
   logic [1:0]    status_ff;
   logic [1:0]    status_in;

   logic accept;
   logic full;
   logic empty;

   mopq_pkg::cell_ctl_type ctl;
   mopq_pkg::entry_type    new_ent;
   mopq_pkg::link_type     links [MAX_SOURCES];
   mopq_pkg::link_type     edge_link;

   logic [CW+mopq_pkg::OCC_W-1:0] count_wide;

   // every cycle is open for a new transaction
   assign busy   = 1'b0;
   assign accept = start && !busy;
   assign full   = (count_ff == CW'(MAX_SOURCES));
   assign empty  = (count_ff == '0);

   // qualify the operation so cells only see changes that really happen
   always_comb begin
      ctl       = '0;
      status_in = mopq_pkg::ST_DONE;
      count_in  = count_ff;
      if (accept) begin
         unique case (req_operation)
            mopq_pkg::OP_INSERT: begin
               if (full) begin
                  status_in = mopq_pkg::ST_FULL;
               end else begin
                  ctl.insert = 1'b1;
                  count_in   = count_ff + CW'(1);
               end
            end
            mopq_pkg::OP_ADVANCE: begin
               if (empty) begin
                  status_in = mopq_pkg::ST_EMPTY;
               end else begin
                  ctl.advance = 1'b1;
               end
            end
            mopq_pkg::OP_RETIRE: begin
               if (empty) begin
                  status_in = mopq_pkg::ST_EMPTY;
               end else begin
                  ctl.retire = 1'b1;
                  count_in   = count_ff - CW'(1);
               end
            end
            default: begin
               // unused code: report the queue untouched
            end
         endcase
      end
   end

   // advance reinserts the head's own source with the new timestamp
   assign new_ent.src   = (req_operation == mopq_pkg::OP_ADVANCE) ? links[0].ent.src
                                                                  : req_source_id;
   assign new_ent.stamp = req_timestamp;

   // row ends: nothing beyond either side
   assign edge_link = '0;

   genvar i;
   generate
      for (i = 0; i < MAX_SOURCES; i++) begin : g_cell
         mopq_cell u_cell (
            .clock   (clock),
            .ctl     (ctl),
            .new_ent (new_ent),
            .first   (i == 0),
            .occ     (CW'(i) < count_ff),
            .left    ((i == 0) ? edge_link : links[(i == 0) ? 0 : i - 1]),
            .right   ((i == MAX_SOURCES - 1) ? edge_link
                                             : links[(i == MAX_SOURCES - 1) ? i : i + 1]),
            .self    (links[i])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
      status_ff <= status_in;
   end

   // response reads the updated row directly
   assign count_wide      = {{mopq_pkg::OCC_W{1'b0}}, count_ff};
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_head_valid  = !empty;
   assign rsp_head_source = empty ? '0 : links[0].ent.src;
   assign rsp_head_time   = empty ? '0 : links[0].ent.stamp;
   assign rsp_occupancy   = count_wide[mopq_pkg::OCC_W-1:0];
   assign rsp_status      = status_ff;

`ifndef ASSERT_OFF
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_SOURCES))
      else $error("queue count above capacity");

   a_rsp_follows : assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("response missing after request");

   a_full_flag : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mopq_pkg::ST_FULL) |-> full && $stable(count_ff))
      else $error("full status with room left");

   a_empty_flag : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == mopq_pkg::ST_EMPTY) |-> !rsp_head_valid)
      else $error("empty status with entries held");
`endif

endmodule
